/* design/lpg_pkg.sv */
// Shared constants, codes and controller/datapath types for the line pixel generator.
`default_nettype none
package lpg_pkg;

  localparam int COORD_WIDTH_DEF = 12;
  localparam int HRES_WIDTH      = 13;
  localparam int COLOR_WIDTH     = 32;
  localparam logic [HRES_WIDTH-1:0] HRES_RESET = 13'd640;

  // Command codes carried in the opcode field
  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } lpg_op_t;

  // Controller states
  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } lpg_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load_line;  // latch endpoints and color of a new line
    logic advance;    // capture the current pixel and step the walk
    logic emit;       // move the captured pixel into the output register
  } lpg_ctrl_t;

  // Status from datapath to controller
  typedef struct packed {
    logic line_active;  // a line has pixels left
    logic out_free;     // output register can take a beat this cycle
  } lpg_stat_t;

endpackage
`default_nettype wire

/* design/lpg_channels.sv */
// Handshake channel interfaces: line commands, pixels and the resolution register write.
`default_nettype none
interface lpg_cmd_if #(
  parameter int COORD_WIDTH = lpg_pkg::COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic                          opcode;
  logic [COORD_WIDTH-1:0]        x_start;
  logic [COORD_WIDTH-1:0]        y_start;
  logic [COORD_WIDTH-1:0]        x_end;
  logic [COORD_WIDTH-1:0]        y_end;
  logic [lpg_pkg::COLOR_WIDTH-1:0] color;

  modport source (output valid, opcode, x_start, y_start, x_end, y_end, color, input ready);
  modport sink   (input valid, opcode, x_start, y_start, x_end, y_end, color, output ready);
endinterface

interface lpg_pixel_if #(
  parameter int COORD_WIDTH = lpg_pkg::COORD_WIDTH_DEF
);
  logic                            valid;
  logic                            ready;
  logic [COORD_WIDTH-1:0]          pixel_x;
  logic [COORD_WIDTH-1:0]          pixel_y;
  logic [2*COORD_WIDTH-1:0]        pixel_offset;
  logic [lpg_pkg::COLOR_WIDTH-1:0] pixel_color;
  logic                            last;

  modport source (output valid, pixel_x, pixel_y, pixel_offset, pixel_color, last, input ready);
  modport sink   (input valid, pixel_x, pixel_y, pixel_offset, pixel_color, last, output ready);
endinterface

interface lpg_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [lpg_pkg::HRES_WIDTH-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

/* design/lpg_ctrl.sv */
// Controller state machine: sequences command acceptance and pixel emission.
`default_nettype none
module lpg_ctrl (
  input  wire               clk,
  input  wire               rst,
  input  wire               cmd_valid,
  input  wire               cmd_opcode,
  input  lpg_pkg::lpg_stat_t stat,
  output logic              cmd_ready,
  output lpg_pkg::lpg_ctrl_t ctrl
);
  import lpg_pkg::*;

  lpg_state_t state;
  lpg_state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next     = state;
    cmd_ready      = 1'b0;
    ctrl.load_line = 1'b0;
    ctrl.advance   = 1'b0;
    ctrl.emit      = 1'b0;
    unique case (state)
      ST_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          if (cmd_opcode == OP_START) begin
            ctrl.load_line = 1'b1;
          end else if (stat.line_active) begin
            ctrl.advance = 1'b1;
            state_next   = ST_EMIT;
          end
          // a step with no active line is dropped
        end
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          ctrl.emit  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

/* design/lpg_datapath.sv */
// Datapath: line registers, incremental quotient walk, offset multiply and output register.
`default_nettype none
module lpg_datapath #(
  parameter int COORD_WIDTH = lpg_pkg::COORD_WIDTH_DEF
) (
  input  wire                             clk,
  input  wire                             rst,
  input  lpg_pkg::lpg_ctrl_t              ctrl,
  output lpg_pkg::lpg_stat_t              stat,
  input  wire [COORD_WIDTH-1:0]           x_start,
  input  wire [COORD_WIDTH-1:0]           y_start,
  input  wire [COORD_WIDTH-1:0]           x_end,
  input  wire [COORD_WIDTH-1:0]           y_end,
  input  wire [lpg_pkg::COLOR_WIDTH-1:0]  color,
  lpg_cfg_if.sink                         cfg,
  lpg_pixel_if.source                     pixel
);
  import lpg_pkg::*;

  localparam int CW   = COORD_WIDTH;
  localparam int OFFW = 2 * COORD_WIDTH;
  localparam int PRODW = COORD_WIDTH + HRES_WIDTH;

  // Configuration and line state
  logic [HRES_WIDTH-1:0]  hres;
  logic                   line_active;
  logic                   y_major;
  logic                   minor_neg;
  logic [CW-1:0]          base_major;
  logic [CW-1:0]          base_minor;
  logic [CW-1:0]          major_len;
  logic [CW-1:0]          minor_len;
  logic [CW-1:0]          step_index;
  logic [CW-1:0]          quot;
  logic [CW-1:0]          rem;
  logic [COLOR_WIDTH-1:0] line_color;

  // Captured pixel awaiting its offset
  logic [CW-1:0] st_x;
  logic [CW-1:0] st_y;
  logic          st_last;

  // Output register
  logic                   out_valid;
  logic [CW-1:0]          out_x;
  logic [CW-1:0]          out_y;
  logic [OFFW-1:0]        out_offset;
  logic [COLOR_WIDTH-1:0] out_color;
  logic                   out_last;

  // Start decode
  logic signed [CW:0] dx;
  logic signed [CW:0] dy;
  logic [CW:0]        adx_w;
  logic [CW:0]        ady_w;
  logic [CW-1:0]      adx;
  logic [CW-1:0]      ady;
  logic               ld_y_major;
  logic               from_start;

  // Walk
  logic [CW-1:0] cur_major;
  logic [CW-1:0] cur_minor;
  logic          cur_last;
  logic [CW:0]   rem_sum;
  logic          rem_wrap;
  logic [CW:0]   rem_sub;

  // Offset
  logic [PRODW-1:0] prod;
  logic [OFFW-1:0]  offset;

  assign cfg.ready = 1'b1;

  // Endpoint deltas and walk direction for a new line
  always_comb begin
    dx         = $signed({1'b0, x_end}) - $signed({1'b0, x_start});
    dy         = $signed({1'b0, y_end}) - $signed({1'b0, y_start});
    adx_w      = dx[CW] ? (CW+1)'(-dx) : dx;
    ady_w      = dy[CW] ? (CW+1)'(-dy) : dy;
    adx        = adx_w[CW-1:0];
    ady        = ady_w[CW-1:0];
    ld_y_major = (adx < ady);
    if (ld_y_major) begin
      from_start = (y_start < y_end);
    end else begin
      from_start = (dx == '0) || (x_start < x_end);
    end
  end

  // Current pixel and remainder update
  always_comb begin
    cur_major = base_major + step_index;
    cur_minor = minor_neg ? (base_minor - quot) : (base_minor + quot);
    cur_last  = (step_index == major_len);
    rem_sum   = {1'b0, rem} + {1'b0, minor_len};
    rem_wrap  = (rem_sum >= {1'b0, major_len});
    rem_sub   = rem_sum - {1'b0, major_len};
  end

  // Resolution register and line state
  always_ff @(posedge clk) begin
    if (rst) begin
      hres        <= HRES_RESET;
      line_active <= 1'b0;
    end else begin
      if (cfg.valid) begin
        hres <= cfg.data;
      end
      if (ctrl.load_line) begin
        line_active <= 1'b1;
      end else if (ctrl.advance && cur_last) begin
        line_active <= 1'b0;
      end
    end
  end

  // Line payload and walk registers
  always_ff @(posedge clk) begin
    if (ctrl.load_line) begin
      y_major    <= ld_y_major;
      minor_neg  <= ld_y_major ? (dx[CW] ^ dy[CW]) : (dy[CW] ^ dx[CW]);
      base_major <= ld_y_major ? (from_start ? y_start : y_end)
                               : (from_start ? x_start : x_end);
      base_minor <= ld_y_major ? (from_start ? x_start : x_end)
                               : (from_start ? y_start : y_end);
      major_len  <= ld_y_major ? ady : adx;
      minor_len  <= ld_y_major ? adx : ady;
      step_index <= '0;
      quot       <= '0;
      rem        <= '0;
      line_color <= color;
    end else if (ctrl.advance) begin
      st_x       <= y_major ? cur_minor : cur_major;
      st_y       <= y_major ? cur_major : cur_minor;
      st_last    <= cur_last;
      step_index <= step_index + 1'b1;
      if (rem_wrap) begin
        rem  <= rem_sub[CW-1:0];
        quot <= quot + 1'b1;
      end else begin
        rem  <= rem_sum[CW-1:0];
      end
    end
  end

  // Linear offset: y times resolution plus x
  always_comb begin
    prod   = PRODW'(st_y) * PRODW'(hres);
    offset = OFFW'(prod) + OFFW'(st_x);
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.emit) begin
      out_valid <= 1'b1;
    end else if (pixel.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit) begin
      out_x      <= st_x;
      out_y      <= st_y;
      out_offset <= offset;
      out_color  <= line_color;
      out_last   <= st_last;
    end
  end

  assign pixel.valid        = out_valid;
  assign pixel.pixel_x      = out_x;
  assign pixel.pixel_y      = out_y;
  assign pixel.pixel_offset = out_offset;
  assign pixel.pixel_color  = out_color;
  assign pixel.last         = out_last;

  assign stat.line_active = line_active;
  assign stat.out_free    = !out_valid || pixel.ready;

endmodule
`default_nettype wire

/* design/line_pixel_generator.sv */
// Line pixel generator top level: major-axis walk with a registered pixel output.
// A start command is accepted while idle and produces no pixel.
// A step command is accepted while idle; its pixel is captured and enters the output register
// once that register is free, and no further command is taken until then. Between capture and
// output sits the single offset multiply-and-add stage.
// Synchronous active-high reset: no line active, output empty, resolution 640.
`default_nettype none
module line_pixel_generator #(
  parameter int COORD_WIDTH = lpg_pkg::COORD_WIDTH_DEF
) (
  input  wire         clk,
  input  wire         rst,
  lpg_cmd_if.sink     cmd,
  lpg_cfg_if.sink     cfg,
  lpg_pixel_if.source pixel
);
  import lpg_pkg::*;

  lpg_ctrl_t ctrl;
  lpg_stat_t stat;
  logic      cmd_ready;

  assign cmd.ready = cmd_ready;

  // Controller
  lpg_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd.valid),
    .cmd_opcode (cmd.opcode),
    .stat       (stat),
    .cmd_ready  (cmd_ready),
    .ctrl       (ctrl)
  );

  // Datapath
  lpg_datapath #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (ctrl),
    .stat    (stat),
    .x_start (cmd.x_start),
    .y_start (cmd.y_start),
    .x_end   (cmd.x_end),
    .y_end   (cmd.y_end),
    .color   (cmd.color),
    .cfg     (cfg),
    .pixel   (pixel)
  );

  // A step on an active line blocks commands until its pixel is loaded
  a_step_blocks: assert property (@(posedge clk) disable iff (rst)
    (cmd.valid && cmd_ready && cmd.opcode == OP_STEP && stat.line_active) |=> !cmd_ready)
    else $error("step beat did not hold off the command channel");

  // The output register is only loaded when it can take a beat
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    ctrl.emit |-> stat.out_free)
    else $error("pixel loaded over an untaken beat");

  // A start always leaves a line active
  a_start_active: assert property (@(posedge clk) disable iff (rst)
    ctrl.load_line |=> stat.line_active)
    else $error("start did not activate a line");

  // An emitted pixel shows up as a valid beat in the next cycle
  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    ctrl.emit |=> pixel.valid)
    else $error("emitted pixel not presented");

endmodule
`default_nettype wire

/* test/line_pixel_generator_test.sv */
// Self-checking testbench for the line pixel generator: directed table plus random line walks.
`default_nettype none
module line_pixel_generator_test;
  timeunit 1ns;
  timeprecision 1ps;
  import lpg_pkg::*;

  localparam int CW     = COORD_WIDTH_DEF;
  localparam int OW     = 2 * CW;
  localparam int CMAX   = (1 << CW) - 1;
  localparam int SETTLE = 8;     // idle cycles added at the end of a drain
  localparam int SEGS   = 6;
  localparam int SEG_ITEMS = 325;

  typedef struct {
    lpg_op_t                op;
    bit [CW-1:0]            xs;
    bit [CW-1:0]            ys;
    bit [CW-1:0]            xe;
    bit [CW-1:0]            ye;
    bit [COLOR_WIDTH-1:0]   color;
  } line_cmd_t;

  typedef struct {
    bit [CW-1:0]          x;
    bit [CW-1:0]          y;
    bit [OW-1:0]          offset;
    bit [COLOR_WIDTH-1:0] color;
    bit                   last;
  } pixel_t;

  // how a directed row is checked
  typedef enum {CHK_MODEL, CHK_NONE, CHK_PIXEL} row_check_t;

  typedef struct {
    line_cmd_t  cmd;
    row_check_t chk;
    pixel_t     pix;
  } table_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #4 clk = ~clk;

  lpg_cmd_if #(.COORD_WIDTH(CW))   cmd_ch ();
  lpg_cfg_if                       cfg_ch ();
  lpg_pixel_if #(.COORD_WIDTH(CW)) pix_ch ();

  line_pixel_generator #(.COORD_WIDTH(CW)) dut (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cmd_ch),
    .cfg   (cfg_ch),
    .pixel (pix_ch)
  );

  // rasterizer state mirrored by the testbench
  bit [HRES_WIDTH-1:0]  hres;
  bit                   walk_active;
  bit [CW-1:0]          walk_base_x;
  bit [CW-1:0]          walk_base_y;
  bit signed [CW:0]     walk_dx;
  bit signed [CW:0]     walk_dy;
  bit                   walk_y_major;
  bit [CW:0]            walk_idx;
  bit [CW:0]            walk_total;
  bit [COLOR_WIDTH-1:0] walk_color;

  pixel_t     pending_pixels[$];
  table_row_t walk_table[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int errors         = 0;
  int items_done     = 0;
  int lines_started  = 0;
  int pixels_checked = 0;
  int hres_writes    = 0;

  function automatic bit signed [CW:0] mag(bit signed [CW:0] v);
    return (v < 0) ? -v : v;
  endfunction

  // minor-axis offset: (minor * i) / major, truncated toward zero
  function automatic int minor_step(bit signed [CW:0] minor, bit signed [CW:0] major,
                                    bit [CW:0] i);
    int q;
    if (major == 0) return 0;
    q = (int'(mag(minor)) * int'(i)) / int'(mag(major));
    return ((minor < 0) != (major < 0)) ? -q : q;
  endfunction

  // advance the mirrored rasterizer by one command; returns 1 when a pixel comes out
  function automatic bit raster_step(input line_cmd_t c, output pixel_t p);
    bit        from_start;
    bit [CW:0] i;
    int        t;
    longint    o;
    p = '{default: '0};
    if (c.op == OP_START) begin
      walk_dx      = $signed({1'b0, c.xe}) - $signed({1'b0, c.xs});
      walk_dy      = $signed({1'b0, c.ye}) - $signed({1'b0, c.ys});
      walk_y_major = mag(walk_dx) < mag(walk_dy);
      if (walk_y_major) begin
        from_start = c.ys < c.ye;
        walk_total = mag(walk_dy);
      end else begin
        from_start = (walk_dx == 0) || (c.xs < c.xe);
        walk_total = mag(walk_dx);
      end
      walk_base_x = from_start ? c.xs : c.xe;
      walk_base_y = from_start ? c.ys : c.ye;
      walk_idx    = '0;
      walk_color  = c.color;
      walk_active = 1'b1;
      return 1'b0;
    end
    if (!walk_active) return 1'b0;
    i = walk_idx;
    if (walk_y_major) begin
      p.y = walk_base_y + i[CW-1:0];
      t   = int'(walk_base_x) + minor_step(walk_dx, walk_dy, i);
      p.x = t[CW-1:0];
    end else begin
      p.x = walk_base_x + i[CW-1:0];
      t   = int'(walk_base_y) + minor_step(walk_dy, walk_dx, i);
      p.y = t[CW-1:0];
    end
    o        = longint'(p.y) * longint'(hres) + longint'(p.x);
    p.offset = o[OW-1:0];
    p.color  = walk_color;
    p.last   = (i >= walk_total);
    if (p.last) walk_active = 1'b0;
    else walk_idx = walk_idx + 1'b1;
    return 1'b1;
  endfunction

  function automatic line_cmd_t start_cmd(bit [CW-1:0] xs, bit [CW-1:0] ys, bit [CW-1:0] xe,
                                          bit [CW-1:0] ye, bit [COLOR_WIDTH-1:0] color);
    line_cmd_t c;
    c.op = OP_START;
    c.xs = xs;
    c.ys = ys;
    c.xe = xe;
    c.ye = ye;
    c.color = color;
    return c;
  endfunction

  function automatic line_cmd_t step_cmd();
    line_cmd_t c;
    c = start_cmd('0, '0, '0, '0, '0);
    c.op = OP_STEP;
    return c;
  endfunction

  function automatic pixel_t px(bit [CW-1:0] x, bit [CW-1:0] y, bit [OW-1:0] offset,
                                bit [COLOR_WIDTH-1:0] color, bit last);
    pixel_t p;
    p.x = x;
    p.y = y;
    p.offset = offset;
    p.color = color;
    p.last = last;
    return p;
  endfunction

  function automatic void add_row(line_cmd_t c, row_check_t k, pixel_t p);
    table_row_t r;
    r.cmd = c;
    r.chk = k;
    r.pix = p;
    walk_table.push_back(r);
  endfunction

  // drive one command beat, wait for acceptance, then record what it should produce
  task automatic send_cmd(line_cmd_t c, row_check_t k, pixel_t golden);
    pixel_t p;
    bit     got;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_ch.valid   <= 1'b1;
    cmd_ch.opcode  <= c.op;
    cmd_ch.x_start <= c.xs;
    cmd_ch.y_start <= c.ys;
    cmd_ch.x_end   <= c.xe;
    cmd_ch.y_end   <= c.ye;
    cmd_ch.color   <= c.color;
    do @(posedge clk); while (cmd_ch.ready !== 1'b1);
    got = raster_step(c, p);
    if (c.op == OP_START) lines_started++;
    if (got || c.op == OP_START) items_done++;
    if (k == CHK_PIXEL) pending_pixels.push_back(golden);
    else if (k == CHK_MODEL && got) pending_pixels.push_back(p);
  endtask

  // hold off the sender until every pixel has come out, then wait out SETTLE
  task automatic drain();
    cmd_ch.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_hres(bit [HRES_WIDTH-1:0] v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= v;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    cfg_ch.valid <= 1'b0;
    hres = v;
    hres_writes++;
  endtask

  function automatic int clamp_coord(int v);
    return (v < 0) ? 0 : ((v > CMAX) ? CMAX : v);
  endfunction

  // one random sequence: mostly a start and its full walk, some cut short or noisy
  task automatic random_line();
    int        x1, y1, x2, y2, span, total, steps, mode;
    line_cmd_t c;
    pixel_t    none;
    none = '{default: '0};
    mode = $urandom_range(0, 19);
    x1 = $urandom_range(0, CMAX);
    y1 = $urandom_range(0, CMAX);
    if ($urandom_range(0, 7) == 0) x1 = $urandom_range(0, 1) * CMAX;
    if ($urandom_range(0, 7) == 0) y1 = $urandom_range(0, 1) * CMAX;
    if (mode == 0) begin
      // stray step, possibly with no line active
      c = step_cmd();
      c.xs = CW'($urandom_range(0, CMAX));
      c.color = $urandom;
      send_cmd(c, CHK_MODEL, none);
      return;
    end
    if (mode <= 2) begin
      x2 = $urandom_range(0, CMAX);
      y2 = $urandom_range(0, CMAX);
      steps = $urandom_range(0, 48);
    end else begin
      span = (mode <= 4) ? 100 : 12;
      x2 = clamp_coord(x1 + $urandom_range(0, 2 * span) - span);
      y2 = clamp_coord(y1 + $urandom_range(0, 2 * span) - span);
      total = ((x2 > x1) ? x2 - x1 : x1 - x2);
      if (((y2 > y1) ? y2 - y1 : y1 - y2) > total) total = (y2 > y1) ? y2 - y1 : y1 - y2;
      steps = total + 1;
      if ($urandom_range(0, 4) == 0) steps += $urandom_range(1, 2);
      if ($urandom_range(0, 9) == 0) steps = $urandom_range(0, total);
    end
    send_cmd(start_cmd(x1[CW-1:0], y1[CW-1:0], x2[CW-1:0], y2[CW-1:0], $urandom),
             CHK_MODEL, none);
    repeat (steps) begin
      c = step_cmd();
      c.xs = CW'($urandom_range(0, CMAX));
      c.ye = CW'($urandom_range(0, CMAX));
      c.color = $urandom;
      send_cmd(c, CHK_MODEL, none);
    end
  endtask

  // receiver stalls
  always @(posedge clk) begin
    pix_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  task automatic note_mismatch(string field, longint want, longint seen);
    errors++;
    if (errors <= 50)
      $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, field, want, seen);
  endtask

  // compare every accepted pixel beat with the oldest expectation
  always @(posedge clk) begin
    pixel_t want;
    if (!rst && pix_ch.valid === 1'b1 && pix_ch.ready === 1'b1) begin
      if (pending_pixels.size() == 0) begin
        errors++;
        if (errors <= 50)
          $display("%0t: unexpected pixel beat x=0x%0h y=0x%0h, expected none",
                   $time, pix_ch.pixel_x, pix_ch.pixel_y);
      end else begin
        want = pending_pixels.pop_front();
        pixels_checked++;
        if (pix_ch.pixel_x !== want.x) note_mismatch("pixel_x", want.x, pix_ch.pixel_x);
        if (pix_ch.pixel_y !== want.y) note_mismatch("pixel_y", want.y, pix_ch.pixel_y);
        if (pix_ch.pixel_offset !== want.offset)
          note_mismatch("pixel_offset", want.offset, pix_ch.pixel_offset);
        if (pix_ch.pixel_color !== want.color)
          note_mismatch("pixel_color", want.color, pix_ch.pixel_color);
        if (pix_ch.last !== want.last) note_mismatch("last", want.last, pix_ch.last);
      end
    end
  end

  // main sequence
  initial begin
    bit [HRES_WIDTH-1:0] hres_plan[SEGS];
    pixel_t none;
    none = '{default: '0};
    cmd_ch.valid   = 1'b0;
    cmd_ch.opcode  = OP_START;
    cmd_ch.x_start = '0;
    cmd_ch.y_start = '0;
    cmd_ch.x_end   = '0;
    cmd_ch.y_end   = '0;
    cmd_ch.color   = '0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.data    = '0;
    pix_ch.ready   = 1'b0;

    // reset state of the mirror
    hres         = HRES_RESET;
    walk_active  = 1'b0;
    walk_base_x  = '0;
    walk_base_y  = '0;
    walk_dx      = '0;
    walk_dy      = '0;
    walk_y_major = 1'b0;
    walk_idx     = '0;
    walk_total   = '0;
    walk_color   = '0;

    // directed rows; pixels typed in only where obvious
    add_row(step_cmd(), CHK_NONE, none);                                   // no line yet
    add_row(start_cmd(12'd0, 12'd0, 12'd0, 12'd0, 32'hFFFF_FFFF), CHK_NONE, none);
    add_row(step_cmd(), CHK_PIXEL, px(12'd0, 12'd0, 24'd0, 32'hFFFF_FFFF, 1'b1));
    add_row(step_cmd(), CHK_NONE, none);                                   // after last
    add_row(start_cmd(12'd4095, 12'd4095, 12'd4095, 12'd4095, 32'h0), CHK_NONE, none);
    add_row(step_cmd(), CHK_PIXEL, px(12'd4095, 12'd4095, 24'd2624895, 32'h0, 1'b1));
    // equal deltas, x major, walked from the far end
    add_row(start_cmd(12'd4095, 12'd0, 12'd0, 12'd4095, 32'hA5A5_A5A5), CHK_NONE, none);
    add_row(step_cmd(), CHK_PIXEL, px(12'd0, 12'd4095, 24'd2620800, 32'hA5A5_A5A5, 1'b0));
    add_row(step_cmd(), CHK_MODEL, none);
    // new start replaces an active line; steep line walked to its end
    add_row(start_cmd(12'd10, 12'd0, 12'd13, 12'd7, 32'h0012_3456), CHK_MODEL, none);
    repeat (8) add_row(step_cmd(), CHK_MODEL, none);
    add_row(step_cmd(), CHK_NONE, none);
    // horizontal, reversed
    add_row(start_cmd(12'd100, 12'd50, 12'd0, 12'd50, 32'h5A5A_5A5A), CHK_MODEL, none);
    repeat (2) add_row(step_cmd(), CHK_MODEL, none);
    // steep, positive minor slope across the full height
    add_row(start_cmd(12'd3, 12'd4095, 12'd0, 12'd0, 32'h00FF_00FF), CHK_MODEL, none);
    repeat (2) add_row(step_cmd(), CHK_MODEL, none);

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (walk_table[n]) send_cmd(walk_table[n].cmd, walk_table[n].chk, walk_table[n].pix);
    drain();

    hres_plan = '{13'd4096, 13'd1, 13'd8191, 13'd0, 13'd640, 13'd640};
    hres_plan[5] = HRES_WIDTH'($urandom_range(1, 4096));

    // random segments: stall mix changes every two, resolution every one
    for (int seg = 0; seg < SEGS; seg++) begin
      int goal;
      case (seg / 2)
        0: begin
          send_idle_pct  = 21;
          recv_stall_pct = 82;
        end
        1: begin
          send_idle_pct  = 82;
          recv_stall_pct = 21;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      write_hres(hres_plan[seg]);
      goal = items_done + SEG_ITEMS;
      while (items_done < goal) random_line();
      drain();
    end

    $display("Covered %0d line starts and %0d checked pixels over %0d resolution writes,",
             lines_started, pixels_checked, hres_writes);
    $display("with sender/receiver stall mixes 21/82, 82/21 and none.");
    if (errors == 0) begin
      $display("line_pixel_generator_test: done, clean");
    end else begin
      $display("line_pixel_generator_test: done, errors");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("line_pixel_generator_test: done, errors");
    $finish;
  end

endmodule
`default_nettype wire
